[sv/sot_pkg.sv]
// ----------------------------------------------------------------------------
// Selection owner table package
// Field widths, command codes and the layout of one stored table entry.
// ----------------------------------------------------------------------------
package sot_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ATOM_W = 29;
  localparam int unsigned TIME_W = 32;

  // Command codes carried on the command input. Code 3 has no meaning and
  // is treated as an unknown command wherever commands are decoded.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_OWNER = 2'd0,
    CMD_GET_OWNER = 2'd1,
    CMD_CONVERT   = 2'd2
  } cmd_e;

  // One table record as it is stored in the entry memory.
  typedef struct packed {
    logic [ATOM_W-1:0] key;
    logic [ATOM_W-1:0] owner;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[sv/sot_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/selection_owner_table.sv]
// Flow: an accepted transaction walks the stored entries one per cycle in the scan state,
//   stopping at the lowest matching index, or at the fill count on a miss; an empty table
//   or an unknown command skips the search. The result then waits in resolve until the
//   output register is free. A new transaction is taken only in idle, after the last one
//   has resolved, so the search has the single read port of the entry memory to itself.
// Reset: the fill count and all handshake state clear at once; no clearing pass is run.
// ----------------------------------------------------------------------------
// Selection owner table
// Keyed table of selection records (key atom, owner id, timestamp) held in one
// synchronous memory and searched linearly, followed by read-modify-write.
// ----------------------------------------------------------------------------
module selection_owner_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sot_pkg::CMD_W-1:0]   command_i,
  input  logic [sot_pkg::ATOM_W-1:0]  key_atom_i,
  input  logic [sot_pkg::ATOM_W-1:0]  owner_id_i,
  input  logic [sot_pkg::TIME_W-1:0]  request_time_i,
  input  logic [sot_pkg::ATOM_W-1:0]  target_atom_i,
  input  logic [sot_pkg::TIME_W-1:0]  now_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sot_pkg::ATOM_W-1:0]  owner_out_o,
  output logic                        hit_o,
  output logic                        status_o
);

  import sot_pkg::*;

  // Index width addresses the memory; the count width can also hold the
  // table size itself, which marks a full table.
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  fill_q;      // number of allocated entries
  logic [IDX_W-1:0]  scan_idx_q;  // index whose read data arrives this cycle

  // The accepted transaction, held for the whole search.
  cmd_e              cmd_q;
  logic              cmd_known_q;
  logic [ATOM_W-1:0] key_q;
  logic [ATOM_W-1:0] owner_q;
  logic [TIME_W-1:0] rtime_q;
  logic [ATOM_W-1:0] target_q;
  logic [TIME_W-1:0] eff_time_q;

  // Outcome of the search: the matching index and the record found there.
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  entry_t            hit_entry_q;

  // Output register that lets a new transaction in while a result waits.
  logic              out_valid_q;
  logic [ATOM_W-1:0] owner_out_q;
  logic              hit_out_q;
  logic              status_q;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic              scan_match;
  logic              scan_last;
  logic              out_free;
  logic              table_full;
  logic              do_alloc;
  logic [ATOM_W-1:0] res_owner;
  logic              res_status;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (fill_q == CNT_W'(TABLE_ENTRIES));

  // The read address runs one entry ahead of the comparison: in idle it
  // points at entry 0 so that the first compare can start right after accept.
  always_comb begin
    case (state_q)
      ST_SCAN: rd_addr = scan_idx_q + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  assign scan_match = (rd_entry.key == key_q);
  assign scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == fill_q;

  // Resolution of the command once the search is over. Only one memory write
  // is ever needed, and it happens in the same cycle the result is loaded.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_q;
    wr_entry   = hit_entry_q;
    do_alloc   = 1'b0;
    res_owner  = '0;
    res_status = 1'b0;
    case (cmd_q)
      CMD_SET_OWNER: begin
        if (hit_q) begin
          // An existing owner is replaced only by a strictly newer request;
          // a zero request time never wins here.
          if (rtime_q > hit_entry_q.stamp) begin
            wr_en          = 1'b1;
            wr_entry.owner = owner_q;
            wr_entry.stamp = rtime_q;
          end
        end else if (!table_full) begin
          do_alloc       = 1'b1;
          wr_en          = 1'b1;
          wr_addr        = fill_q[IDX_W-1:0];
          wr_entry.key   = key_q;
          wr_entry.owner = owner_q;
          wr_entry.stamp = eff_time_q;
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_GET_OWNER: begin
        if (hit_q) begin
          res_owner = hit_entry_q.owner;
        end
      end
      CMD_CONVERT: begin
        if (hit_q) begin
          wr_en          = 1'b1;
          wr_entry.key   = target_q;
          wr_entry.stamp = eff_time_q;
        end
      end
      default: begin
      end
    endcase
    if (!cmd_known_q) begin
      wr_en    = 1'b0;
      do_alloc = 1'b0;
    end
  end

  sot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && (state_q == ST_RESOLVE) && out_free),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scan_idx_q  <= '0;
      cmd_q       <= CMD_SET_OWNER;
      cmd_known_q <= 1'b0;
      key_q       <= '0;
      owner_q     <= '0;
      rtime_q     <= '0;
      target_q    <= '0;
      eff_time_q  <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_entry_q <= '0;
      out_valid_q <= 1'b0;
      owner_out_q <= '0;
      hit_out_q   <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      // In resolve a taken result is replaced by the new one below.
      if (out_valid_q && out_ready_i && (state_q != ST_RESOLVE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q       <= cmd_e'(command_i);
            cmd_known_q <= (command_i == CMD_SET_OWNER) ||
                           (command_i == CMD_GET_OWNER) ||
                           (command_i == CMD_CONVERT);
            key_q       <= key_atom_i;
            owner_q     <= owner_id_i;
            rtime_q     <= request_time_i;
            target_q    <= target_atom_i;
            eff_time_q  <= (request_time_i == '0) ? now_i : request_time_i;
            hit_q       <= 1'b0;
            scan_idx_q  <= '0;
            // An empty table or an unknown command needs no search.
            if ((fill_q == '0) || !((command_i == CMD_SET_OWNER) ||
                                    (command_i == CMD_GET_OWNER) ||
                                    (command_i == CMD_CONVERT))) begin
              state_q <= ST_RESOLVE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_match) begin
            hit_q       <= 1'b1;
            hit_idx_q   <= scan_idx_q;
            hit_entry_q <= rd_entry;
            state_q     <= ST_RESOLVE;
          end else if (scan_last) begin
            state_q <= ST_RESOLVE;
          end else begin
            scan_idx_q <= scan_idx_q + IDX_W'(1);
          end
        end
        ST_RESOLVE: begin
          // Wait here until the output register can take the result, so the
          // memory write and the result always leave together.
          if (out_free) begin
            out_valid_q <= 1'b1;
            owner_out_q <= res_owner;
            hit_out_q   <= hit_q && cmd_known_q;
            status_q    <= res_status && cmd_known_q;
            if (do_alloc) begin
              fill_q <= fill_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign owner_out_o = owner_out_q;
  assign hit_o       = hit_out_q;
  assign status_o    = status_q;

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count exceeds table size");

  // Entries are allocated one at a time: the fill count only steps by one.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("fill count jumped");

  // The search never compares an entry that has not been allocated.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(scan_idx_q) < fill_q))
    else $error("search past allocated entries");

  // A full status is only reported for a miss, and an owner only for a hit.
  a_status_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> !hit_o)
    else $error("full status reported on a hit");

  a_owner_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (owner_out_o != '0)) |-> hit_o)
    else $error("owner reported without a hit");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Selection owner table testbench
// Sends set owner, get owner, convert and undefined command transactions into
// the table. A shadow copy of the table works out each reply, and every reply
// is compared field by field while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sot_pkg::*;

  localparam int unsigned ENTRIES = 16;
  // Code 3 is not an enum member; the table must answer it with all zeros.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [ATOM_W-1:0] ATOM_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned KEY_POOL = 28;

  // One request transaction, in the order of the payload ports.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ATOM_W-1:0] key;
    logic [ATOM_W-1:0] owner;
    logic [TIME_W-1:0] rtime;
    logic [ATOM_W-1:0] target;
    logic [TIME_W-1:0] now;
  } request_t;

  // One reply transaction.
  typedef struct packed {
    logic [ATOM_W-1:0] owner;
    logic              hit;
    logic              status;
  } reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command_i = '0;
  logic [ATOM_W-1:0] key_atom_i = '0;
  logic [ATOM_W-1:0] owner_id_i = '0;
  logic [TIME_W-1:0] request_time_i = '0;
  logic [ATOM_W-1:0] target_atom_i = '0;
  logic [TIME_W-1:0] now_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ATOM_W-1:0] owner_out_o;
  logic              hit_o;
  logic              status_o;

  selection_owner_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .key_atom_i    (key_atom_i),
    .owner_id_i    (owner_id_i),
    .request_time_i(request_time_i),
    .target_atom_i (target_atom_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .owner_out_o   (owner_out_o),
    .hit_o         (hit_o),
    .status_o      (status_o)
  );

  // Shadow copy of the table. Entries fill in index order and are never freed.
  bit                shadow_valid [ENTRIES];
  logic [ATOM_W-1:0] shadow_key   [ENTRIES];
  logic [ATOM_W-1:0] shadow_owner [ENTRIES];
  logic [TIME_W-1:0] shadow_time  [ENTRIES];
  int unsigned       shadow_fill = 0;

  // Replies owed by the table, oldest first.
  reply_t            replies_due [$];
  int unsigned       failures = 0;

  // Keys drawn from a small pool so that lookups hit often and the table fills.
  logic [ATOM_W-1:0] key_pool [KEY_POOL];

  // Sender burst state and receiver stall state.
  int unsigned       burst_left = 0;
  int unsigned       next_gap = 0;
  bit                offering = 1'b0;
  bit                hold_off_req = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       run_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Returns the lowest valid index holding the key, or -1 when it is absent.
  function automatic int find_entry(logic [ATOM_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one accepted request to the shadow table and returns the reply it
  // must produce.
  function automatic reply_t table_update(request_t req);
    reply_t            res = '0;
    int                idx;
    logic [TIME_W-1:0] stamp;
    // A zero request time stands for the current time, but only where a time
    // is written fresh; the update of an existing owner compares the raw value.
    stamp = (req.rtime == '0) ? req.now : req.rtime;
    if (req.cmd == CMD_UNKNOWN) return res;
    idx = find_entry(req.key);
    res.hit = (idx >= 0);
    case (req.cmd)
      CMD_SET_OWNER: begin
        if (idx >= 0) begin
          if (req.rtime > shadow_time[idx]) begin
            shadow_owner[idx] = req.owner;
            shadow_time[idx] = req.rtime;
          end
        end else if (shadow_fill < ENTRIES) begin
          shadow_valid[shadow_fill] = 1'b1;
          shadow_key[shadow_fill] = req.key;
          shadow_owner[shadow_fill] = req.owner;
          shadow_time[shadow_fill] = stamp;
          shadow_fill++;
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_GET_OWNER: begin
        if (idx >= 0) res.owner = shadow_owner[idx];
      end
      default: begin
        if (idx >= 0) begin
          shadow_key[idx] = req.target;
          shadow_time[idx] = stamp;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] wanted, logic [31:0] seen);
    if (seen !== wanted) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, wanted, seen);
      failures++;
    end
  endtask

  // Monitor. All values are sampled as they stood just before the edge, so the
  // order of processes within the step does not matter. The reply check runs
  // before the new request is applied, since a reply can never belong to a
  // request accepted at the same edge.
  always @(posedge clk_i) begin
    reply_t due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply with no request waiting: owner %h hit %b status %b",
                   $time, owner_out_o, hit_o, status_o);
          failures++;
        end else begin
          due = replies_due.pop_front();
          report_field("owner_out", 32'(due.owner), 32'(owner_out_o));
          report_field("hit", 32'(due.hit), 32'(hit_o));
          report_field("status", 32'(due.status), 32'(status_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        replies_due.push_back(table_update({command_i, key_atom_i, owner_id_i,
                                            request_time_i, target_atom_i, now_i}));
      end
    end
  end

  // Receiver. Runs of ready alternate with short stalls, and some runs have
  // no stall after them at all. A hold-off request stalls the reply channel
  // for a long stretch so that the table backs up into its request channel.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left = HOLD_OFF_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (run_left != 0) begin
        run_left--;
      end else begin
        run_left = $urandom_range(1, 24);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high into the next transaction of a burst; at the end of a burst it
  // drops here, in the step of the acceptance, and the gap is spent on entry
  // to the next call.
  task automatic send_request(request_t req);
    repeat (next_gap) @(posedge clk_i);
    {command_i, key_atom_i, owner_id_i, request_time_i, target_atom_i, now_i} <= req;
    in_valid_i <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left != 0) begin
      burst_left--;
      next_gap = 0;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 10);
      next_gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Stops offering and waits until every owed reply has arrived. The first
  // edge lets the monitor record a transaction accepted in this step.
  task automatic wait_replies();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Random request. Keys come mostly from the pool or from live entries, and
  // request times often straddle the stored time so the strictly greater rule
  // is exercised from both sides.
  function automatic request_t random_request();
    request_t req;
    int       pick;
    int       idx;
    pick = $urandom_range(0, 99);
    req.cmd = (pick < 40) ? CMD_SET_OWNER :
              (pick < 70) ? CMD_GET_OWNER :
              (pick < 93) ? CMD_CONVERT : CMD_UNKNOWN;
    pick = $urandom_range(0, 9);
    if (pick < 7) req.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    else if (pick < 9 && shadow_fill != 0) req.key = shadow_key[$urandom_range(0, shadow_fill - 1)];
    else req.key = ATOM_W'($urandom);
    pick = $urandom_range(0, 9);
    req.owner = (pick == 0) ? '0 : (pick == 1) ? ATOM_MAX : ATOM_W'($urandom);
    req.now = $urandom;
    idx = find_entry(req.key);
    pick = $urandom_range(0, 9);
    if (pick < 3) req.rtime = '0;
    else if (pick < 7 && idx >= 0) req.rtime = shadow_time[idx] + $urandom_range(0, 2) - 1;
    else req.rtime = $urandom;
    req.target = ($urandom_range(0, 9) < 6) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                             : ATOM_W'($urandom);
    return req;
  endfunction

  // A random key that no live entry holds at the time of the call.
  function automatic logic [ATOM_W-1:0] fresh_key();
    logic [ATOM_W-1:0] key;
    do key = ATOM_W'($urandom); while (find_entry(key) >= 0);
    return key;
  endfunction

  // Lookups and a conversion on the empty table, the undefined command, and the
  // first allocation taking the current time in place of a zero request time.
  task automatic test_empty_table();
    send_request('{CMD_GET_OWNER, ATOM_W'(0), ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_CONVERT, ATOM_MAX, ATOM_W'(0), TIME_W'(0), ATOM_W'(1), TIME_MAX});
    send_request('{CMD_UNKNOWN, ATOM_MAX, ATOM_MAX, TIME_MAX, ATOM_MAX, TIME_MAX});
    send_request('{CMD_SET_OWNER, ATOM_W'(0), ATOM_W'(5), TIME_W'(0), ATOM_W'(0), TIME_MAX});
    send_request('{CMD_GET_OWNER, ATOM_W'(0), ATOM_MAX, TIME_MAX, ATOM_MAX, TIME_W'(0)});
    // The undefined command reports no hit even though key 0 is now present.
    send_request('{CMD_UNKNOWN, ATOM_W'(0), ATOM_MAX, TIME_MAX, ATOM_MAX, TIME_MAX});
  endtask

  // Owner updates on an existing key: a zero time and an equal time leave the
  // entry alone, a greater time replaces owner and time.
  task automatic test_owner_update_rules();
    send_request('{CMD_SET_OWNER, ATOM_MAX, ATOM_MAX, TIME_W'(100), ATOM_W'(0), TIME_W'(7)});
    send_request('{CMD_SET_OWNER, ATOM_MAX, ATOM_W'(1), TIME_W'(0), ATOM_W'(0), TIME_MAX});
    send_request('{CMD_SET_OWNER, ATOM_MAX, ATOM_W'(2), TIME_W'(100), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_SET_OWNER, ATOM_MAX, ATOM_W'(3), TIME_W'(101), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_SET_OWNER, ATOM_W'(0), ATOM_MAX, TIME_MAX, ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_MAX, ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_W'(0), ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
  endtask

  // Conversion onto a key that already exists leaves two entries with one key;
  // the lower one wins until it is renamed away, then the upper one shows.
  task automatic test_convert();
    send_request('{CMD_CONVERT, ATOM_MAX, ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(50)});
    send_request('{CMD_GET_OWNER, ATOM_MAX, ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_W'(0), ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_CONVERT, ATOM_W'(0), ATOM_W'(0), TIME_W'(9), ATOM_W'('h0AAAAAAA),
                   TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_W'(0), ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_W'('h0AAAAAAA), ATOM_W'(0), TIME_W'(0), ATOM_W'(0),
                   TIME_W'(0)});
    send_request('{CMD_SET_OWNER, ATOM_W'('h0AAAAAAA), ATOM_W'('h15555555), TIME_W'(10),
                   ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, ATOM_W'('h0AAAAAAA), ATOM_W'(0), TIME_W'(0), ATOM_W'(0),
                   TIME_W'(0)});
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // Enough fresh keys to fill whatever room is left plus one, so at least one
  // insert is dropped with the full status. Then a hit and two misses on the full
  // table, none of which may report full.
  task automatic test_full_table();
    wait_replies();
    repeat (ENTRIES + 1) begin
      send_request('{CMD_SET_OWNER, fresh_key(), ATOM_W'($urandom), TIME_W'($urandom),
                     ATOM_W'($urandom), TIME_W'($urandom)});
    end
    wait_replies();
    send_request('{CMD_SET_OWNER, shadow_key[0], ATOM_MAX, TIME_MAX, ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_GET_OWNER, fresh_key(), ATOM_W'(0), TIME_W'(0), ATOM_W'(0), TIME_W'(0)});
    send_request('{CMD_CONVERT, fresh_key(), ATOM_W'(0), TIME_W'(0), ATOM_MAX, TIME_MAX});
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the table has to stall its request channel until replies drain again.
  task automatic test_input_backpressure();
    hold_off_req = 1'b1;
    test_random_traffic(40);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    key_pool[0] = '0;
    key_pool[1] = ATOM_MAX;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = ATOM_W'($urandom);

    test_empty_table();
    test_owner_update_rules();
    test_convert();
    test_random_traffic(350);
    test_full_table();
    test_input_backpressure();
    test_random_traffic(510);

    // A search over a full table plus the write-back bounds the drain time.
    wait_replies();
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
